// ----- hw/rtl/mtcg_pkg.sv -----
package mtcg_pkg;

    // Default sizes of the tone store and of the phase and table words
    localparam int MAX_TONES_DEF  = 16;
    localparam int PHASE_BITS_DEF = 24;
    localparam int TABLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int OPCODE_W     = 2;
    localparam int TONE_INDEX_W = 4;
    localparam int FREQ_W       = 24;
    localparam int SAMPLE_W     = 16;
    localparam int COUNT_W      = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

    // Quarter-wave cosine table: pi/2 in Q30 and length of the series
    localparam logic [63:0] PI_HALF_Q30  = 64'd1686629713;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam int          SERIES_TERMS = 12;

    // Entry k of the quarter table in Q15, from a Taylor series in Q30.
    // Only ever called with constant arguments, so it folds to a constant.
    function automatic logic [14:0] cos_q15(input int unsigned k,
                                            input int unsigned table_bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] acc;
        int                 n;
        x    = (PI_HALF_Q30 * 64'(k)) >> (table_bits - 2);
        term = ONE_Q30;
        acc  = $signed(ONE_Q30);
        for (n = 1; n <= SERIES_TERMS; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd2;
                2:       term = term / 64'd12;
                3:       term = term / 64'd30;
                4:       term = term / 64'd56;
                5:       term = term / 64'd90;
                6:       term = term / 64'd132;
                7:       term = term / 64'd182;
                8:       term = term / 64'd240;
                9:       term = term / 64'd306;
                10:      term = term / 64'd380;
                11:      term = term / 64'd462;
                12:      term = term / 64'd552;
                default: term = term;
            endcase
            if (n[0])
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = '0;
        acc = (acc + 64'sd16384) >>> 15;
        if (acc > 64'sd32767)
            acc = 64'sd32767;
        return 15'(acc);
    endfunction

endpackage

// ----- hw/rtl/mtcg_ram.sv -----
module mtcg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/mtcg_cos_lut.sv -----
module mtcg_cos_lut #(
    parameter int TABLE_BITS = mtcg_pkg::TABLE_BITS_DEF
) (
    input  logic [TABLE_BITS-1:0]               idx,
    output logic signed [mtcg_pkg::SAMPLE_W-1:0] cos_val
);

    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int TAW     = TABLE_BITS - 1;

    logic [14:0]                         cos_tab [QUARTER + 1];
    logic [TABLE_BITS-3:0]               r;
    logic [TAW-1:0]                      addr;
    logic                                mirror;
    logic                                neg;
    logic signed [mtcg_pkg::SAMPLE_W-1:0] mag;

    genvar k;
    generate
        for (k = 0; k <= QUARTER; k++)
        begin : g_tab
            assign cos_tab[k] = mtcg_pkg::cos_q15(k, TABLE_BITS);
        end
    endgenerate

    // Quadrants 1 and 3 read the table mirrored, quadrants 1 and 2 negate
    always_comb
    begin
        r       = idx[TABLE_BITS-3:0];
        mirror  = idx[TABLE_BITS-2];
        neg     = idx[TABLE_BITS-1] ^ idx[TABLE_BITS-2];
        addr    = mirror ? (TAW'(QUARTER) - {1'b0, r}) : {1'b0, r};
        mag     = $signed({1'b0, cos_tab[addr]});
        cos_val = neg ? -mag : mag;
    end

endmodule

// ----- hw/rtl/multi_tone_cosine_generator_top.sv -----
// Multi-tone cosine generator. A load item (opcode 0) stores one tone's frequency word,
// saturated to half the sample rate, and a clear item (opcode 1) zeroes every phase; each
// completes without leaving idle. An emit item (opcode 2) walks all MAX_TONES tones
// through one shared table lookup and adder, one tone a cycle with the phase store written
// back behind the read, then divides the sum by the active tone count one quotient bit a
// cycle with a shared compare-and-subtract, and then waits for a free output register.
// The sum is SUM_W = 16 + clog2(MAX_TONES) bits wide. in_stall is high while an emit item
// is in progress; a finished sample waits in the output register, and the next item is
// still taken, but an emit item holds its result until that register is free.
// tone_count must be written only while idle; the block itself does not enforce it. Zero
// counts as one and values above MAX_TONES saturate.
module multi_tone_cosine_generator_top #(
    parameter int MAX_TONES  = mtcg_pkg::MAX_TONES_DEF,
    parameter int PHASE_BITS = mtcg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS = mtcg_pkg::TABLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    tone_count_we,
    input  logic [mtcg_pkg::COUNT_W-1:0]            tone_count,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [mtcg_pkg::OPCODE_W-1:0]           opcode,
    input  logic [mtcg_pkg::TONE_INDEX_W-1:0]       tone_index,
    input  logic [mtcg_pkg::FREQ_W-1:0]             freq_word,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [mtcg_pkg::SAMPLE_W-1:0]    sample
);

    localparam int AW    = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int CNT_W = $clog2(MAX_TONES + 1);
    localparam int SUM_W = mtcg_pkg::SAMPLE_W + $clog2(MAX_TONES);
    localparam int DCW   = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]                          state_reg, state_next;
    logic [mtcg_pkg::COUNT_W-1:0]        tone_count_reg;
    logic [MAX_TONES-1:0]                freq_valid_reg, freq_valid_next;
    logic [MAX_TONES-1:0]                phase_valid_reg, phase_valid_next;
    logic [AW:0]                         rd_cnt_reg, rd_cnt_next;
    logic                                s1_valid_reg, s1_valid_next;
    logic [AW-1:0]                       s1_idx_reg, s1_idx_next;
    logic signed [SUM_W-1:0]             sum_reg, sum_next;
    logic                                neg_reg, neg_next;
    logic [SUM_W-1:0]                    quo_reg, quo_next;
    logic [CNT_W-1:0]                    rem_reg, rem_next;
    logic [DCW-1:0]                      div_cnt_reg, div_cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [mtcg_pkg::SAMPLE_W-1:0] sample_reg, sample_next;

    logic                                accept_in;
    logic                                out_free;
    logic [CNT_W-1:0]                    count_eff;
    logic                                freq_we;
    logic [PHASE_BITS-1:0]               freq_sat;
    logic                                rd_en;
    logic [PHASE_BITS-1:0]               phase_rdata;
    logic [PHASE_BITS-1:0]               freq_rdata;
    logic [PHASE_BITS-1:0]               phase_cur;
    logic [PHASE_BITS-1:0]               freq_cur;
    logic [PHASE_BITS-1:0]               phase_upd;
    logic signed [mtcg_pkg::SAMPLE_W-1:0] cos_val;
    logic                                tone_active;
    logic [CNT_W:0]                      shifted;
    logic [SUM_W-1:0]                    quo_signed;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    always_comb
    begin
        if (tone_count_reg == '0)
            count_eff = CNT_W'(1);
        else if (32'(tone_count_reg) > 32'(MAX_TONES))
            count_eff = CNT_W'(MAX_TONES);
        else
            count_eff = CNT_W'(tone_count_reg);
    end

    // Clamp the loaded word to half a cycle per sample
    always_comb
    begin
        if (33'(freq_word) > (33'd1 << (PHASE_BITS - 1)))
            freq_sat = PHASE_BITS'(33'd1 << (PHASE_BITS - 1));
        else
            freq_sat = PHASE_BITS'(freq_word);
    end

    assign freq_we = accept_in && (opcode == mtcg_pkg::OP_LOAD)
                     && (32'(tone_index) < 32'(MAX_TONES));
    assign rd_en   = (state_reg == ST_RUN) && (32'(rd_cnt_reg) < 32'(MAX_TONES));

    // Entries never written read as zero
    assign phase_cur   = phase_valid_reg[s1_idx_reg] ? phase_rdata : '0;
    assign freq_cur    = freq_valid_reg[s1_idx_reg] ? freq_rdata : '0;
    assign phase_upd   = phase_cur + freq_cur;
    assign tone_active = (32'(s1_idx_reg) < 32'(count_eff));

    mtcg_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (MAX_TONES)
    ) u_freq_ram (
        .clk   (clk),
        .we    (freq_we),
        .waddr (AW'(tone_index)),
        .wdata (freq_sat),
        .re    (rd_en),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (freq_rdata)
    );

    mtcg_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (MAX_TONES)
    ) u_phase_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (phase_upd),
        .re    (rd_en),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (phase_rdata)
    );

    mtcg_cos_lut #(
        .TABLE_BITS (TABLE_BITS)
    ) u_cos_lut (
        .idx     (phase_cur[PHASE_BITS-1 -: TABLE_BITS]),
        .cos_val (cos_val)
    );

    always_comb
    begin
        state_next       = state_reg;
        freq_valid_next  = freq_valid_reg;
        phase_valid_next = phase_valid_reg;
        rd_cnt_next      = rd_cnt_reg;
        s1_valid_next    = rd_en;
        s1_idx_next      = rd_cnt_reg[AW-1:0];
        sum_next         = sum_reg;
        neg_next         = neg_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        out_valid_next   = out_valid_reg;
        sample_next      = sample_reg;
        shifted          = {rem_reg, quo_reg[SUM_W-1]};
        quo_signed       = neg_reg ? ('0 - quo_reg) : quo_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    unique case (opcode)
                        mtcg_pkg::OP_LOAD:
                        begin
                            if (freq_we)
                                freq_valid_next[AW'(tone_index)] = 1'b1;
                        end
                        mtcg_pkg::OP_CLEAR:
                        begin
                            phase_valid_next = '0;
                        end
                        mtcg_pkg::OP_SAMPLE:
                        begin
                            rd_cnt_next = '0;
                            sum_next    = '0;
                            state_next  = ST_RUN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (rd_en)
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                // Write back the advanced phase; sum only the active tones
                if (s1_valid_reg)
                begin
                    phase_valid_next[s1_idx_reg] = 1'b1;
                    if (tone_active)
                        sum_next = sum_reg + SUM_W'(cos_val);
                    if (s1_idx_reg == AW'(MAX_TONES - 1))
                        state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                neg_next     = sum_reg[SUM_W-1];
                quo_next     = sum_reg[SUM_W-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
                rem_next     = '0;
                div_cnt_next = DCW'(SUM_W);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // Restoring divide of the magnitude, one quotient bit a cycle
                if (div_cnt_reg != '0)
                begin
                    if (shifted >= {1'b0, count_eff})
                    begin
                        rem_next = CNT_W'(shifted - {1'b0, count_eff});
                        quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = CNT_W'(shifted);
                        quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = $signed(mtcg_pkg::SAMPLE_W'(quo_signed));
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tone_count_reg  <= mtcg_pkg::COUNT_RESET;
            freq_valid_reg  <= '0;
            phase_valid_reg <= '0;
            rd_cnt_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (tone_count_we)
                tone_count_reg <= tone_count;
            freq_valid_reg  <= freq_valid_next;
            phase_valid_reg <= phase_valid_next;
            rd_cnt_reg      <= rd_cnt_next;
            s1_valid_reg    <= s1_valid_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= s1_idx_next;
        sum_reg    <= sum_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        sample_reg <= sample_next;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_TONES   = mtcg_pkg::MAX_TONES_DEF;
    localparam int PH_BITS     = mtcg_pkg::PHASE_BITS_DEF;
    localparam int TAB_BITS    = mtcg_pkg::TABLE_BITS_DEF;
    localparam int QUARTER     = 1 << (TAB_BITS - 2);
    localparam int GAP_MAX     = 14;
    localparam int SETTLE_CYC  = 60;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYC    = 800;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_SETS = 5;
    localparam int SET_ITEMS   = 100;

    localparam logic [mtcg_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [mtcg_pkg::FREQ_W-1:0]   FREQ_HALF = 24'h800000;
    localparam logic [mtcg_pkg::FREQ_W-1:0]   FREQ_MAX  = 24'hFFFFFF;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 tone_count_we = 1'b0;
    logic [mtcg_pkg::COUNT_W-1:0]         tone_count    = '0;
    logic                                 in_valid      = 1'b0;
    logic                                 in_stall;
    logic [mtcg_pkg::OPCODE_W-1:0]        opcode        = '0;
    logic [mtcg_pkg::TONE_INDEX_W-1:0]    tone_index    = '0;
    logic [mtcg_pkg::FREQ_W-1:0]          freq_word     = '0;
    logic                                 out_valid;
    logic                                 out_stall     = 1'b0;
    logic signed [mtcg_pkg::SAMPLE_W-1:0] sample;

    // Predictor state
    int                                   cos_quarter [QUARTER+1];
    logic [PH_BITS-1:0]                   model_freq  [NUM_TONES];
    logic [PH_BITS-1:0]                   model_phase [NUM_TONES];
    logic [mtcg_pkg::COUNT_W-1:0]         active_count;
    logic signed [mtcg_pkg::SAMPLE_W-1:0] expected_samples [$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   tx_gap_max  = 0;
    int   rx_gap_max  = 0;
    int   rx_wait     = 0;
    logic hold_active = 1'b0;
    event hold_start;

    multi_tone_cosine_generator_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tone_count_we (tone_count_we),
        .tone_count    (tone_count),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .tone_index    (tone_index),
        .freq_word     (freq_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Quarter-wave table: Taylor series in Q30, rounded to Q15
    function automatic void build_cos_quarter();
        logic [63:0] x;
        logic [63:0] term;
        longint      acc;
        int          k;
        int          n;
        for (k = 0; k <= QUARTER; k++)
        begin
            x    = (mtcg_pkg::PI_HALF_Q30 * 64'(k)) / 64'(QUARTER);
            term = mtcg_pkg::ONE_Q30;
            acc  = longint'(mtcg_pkg::ONE_Q30);
            for (n = 1; n <= mtcg_pkg::SERIES_TERMS; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / (64'(2 * n - 1) * 64'(2 * n));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 16384) >>> 15;
            if (acc > 32767)
                acc = 32767;
            cos_quarter[k] = int'(acc);
        end
    endfunction

    function automatic int cos_of_phase(input logic [PH_BITS-1:0] ph);
        logic [TAB_BITS-1:0] idx;
        logic [1:0]          quad;
        int                  r;
        int                  mag;
        idx  = ph[PH_BITS-1 -: TAB_BITS];
        quad = idx[TAB_BITS-1 -: 2];
        r    = int'(idx[TAB_BITS-3:0]);
        // odd quadrants read the table backwards, the middle two are negative
        mag  = quad[0] ? cos_quarter[QUARTER - r] : cos_quarter[r];
        return (quad[0] ^ quad[1]) ? -mag : mag;
    endfunction

    function automatic logic signed [mtcg_pkg::SAMPLE_W-1:0] next_sample();
        int n_active;
        int total;
        int j;
        n_active = int'(active_count);
        if (n_active == 0)
            n_active = 1;
        if (n_active > NUM_TONES)
            n_active = NUM_TONES;
        total = 0;
        for (j = 0; j < n_active; j++)
            total += cos_of_phase(model_phase[j]);
        // advance every tone, active or not
        for (j = 0; j < NUM_TONES; j++)
            model_phase[j] = model_phase[j] + model_freq[j];
        return mtcg_pkg::SAMPLE_W'(total / n_active);
    endfunction

    function automatic void apply_item(input logic [mtcg_pkg::OPCODE_W-1:0] op,
                                       input logic [mtcg_pkg::TONE_INDEX_W-1:0] idx,
                                       input logic [mtcg_pkg::FREQ_W-1:0] word);
        int j;
        case (op)
            mtcg_pkg::OP_LOAD:
                if (int'(idx) < NUM_TONES)
                    model_freq[idx] = (word > FREQ_HALF) ? FREQ_HALF : word;
            mtcg_pkg::OP_CLEAR:
                for (j = 0; j < NUM_TONES; j++)
                    model_phase[j] = '0;
            mtcg_pkg::OP_SAMPLE:
                expected_samples.push_back(next_sample());
            default:
                ;
        endcase
    endfunction

    // Leaves in_valid high on return so a back-to-back item needs no gap
    task automatic send_item(input logic [mtcg_pkg::OPCODE_W-1:0] op,
                             input logic [mtcg_pkg::TONE_INDEX_W-1:0] idx,
                             input logic [mtcg_pkg::FREQ_W-1:0] word);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        tone_index <= idx;
        freq_word  <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_item(op, idx, word);
    endtask

    task automatic wait_idle();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (expected_samples.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        // then let the block settle before returning
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_tone_count(input logic [mtcg_pkg::COUNT_W-1:0] value);
        wait_idle();
        tone_count_we <= 1'b1;
        tone_count    <= value;
        @(posedge clk);
        active_count = value;
        tone_count_we <= 1'b0;
    endtask

    // Receive side: check each accepted item, then draw the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample: expected none, actual %0d", sample);
                fail_count++;
            end
            else if (sample !== expected_samples[0])
            begin
                $error("sample: expected %0d, actual %0d", expected_samples[0], sample);
                fail_count++;
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
            rx_wait = $urandom_range(0, rx_gap_max);
        end
        if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= hold_active;
    end

    always
    begin
        @(hold_start);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_active <= 1'b0;
    end

    task automatic test_reset_state();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        send_item(mtcg_pkg::OP_SAMPLE, '1, FREQ_MAX);
    endtask

    task automatic test_directed();
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        // quarter-cycle tone walks through all four quadrants
        send_item(mtcg_pkg::OP_LOAD, 4'd0, 24'h400000);
        repeat (4) send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        // words above one half saturate
        send_item(mtcg_pkg::OP_LOAD, 4'd0, FREQ_MAX);
        send_item(mtcg_pkg::OP_LOAD, 4'd1, FREQ_HALF + 24'd1);
        send_item(mtcg_pkg::OP_LOAD, 4'd2, '0);
        send_item(mtcg_pkg::OP_LOAD, 4'd15, FREQ_HALF);
        set_tone_count(5'd16);
        repeat (3) send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        send_item(mtcg_pkg::OP_CLEAR, '1, FREQ_MAX);
        send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        // unused opcode changes nothing
        send_item(OP_UNUSED, '1, FREQ_MAX);
        send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        // zero count acts as one, large counts clamp to the tone store
        set_tone_count(5'd0);
        send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        set_tone_count(5'd17);
        send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        set_tone_count(5'd31);
        send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
        set_tone_count(5'd2);
        send_item(mtcg_pkg::OP_LOAD, 4'd1, 24'd1);
        repeat (2) send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
    endtask

    task automatic send_random_item();
        int                                pick;
        logic [mtcg_pkg::TONE_INDEX_W-1:0] idx;
        logic [mtcg_pkg::FREQ_W-1:0]       word;
        pick = $urandom_range(0, 99);
        idx  = mtcg_pkg::TONE_INDEX_W'($urandom_range(0, NUM_TONES - 1));
        word = mtcg_pkg::FREQ_W'($urandom);
        if (pick < 55)
            send_item(mtcg_pkg::OP_SAMPLE, idx, word);
        else if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:       word = mtcg_pkg::FREQ_W'($urandom);
                1:       word = mtcg_pkg::FREQ_W'($urandom_range(0, 4096));
                2:       word = FREQ_HALF - mtcg_pkg::FREQ_W'($urandom_range(0, 255));
                default: word = mtcg_pkg::FREQ_W'($urandom_range(0, 32'h800000));
            endcase
            send_item(mtcg_pkg::OP_LOAD, idx, word);
        end
        else if (pick < 92)
            send_item(mtcg_pkg::OP_CLEAR, idx, word);
        else
            send_item(OP_UNUSED, idx, word);
    endtask

    task automatic test_random();
        int s;
        int k;
        for (s = 0; s < RANDOM_SETS; s++)
        begin
            case (s)
                0:       set_tone_count(5'd16);
                1:       set_tone_count(5'd1);
                2:       set_tone_count(mtcg_pkg::COUNT_W'($urandom_range(0, 31)));
                3:       set_tone_count(5'd31);
                default: set_tone_count(mtcg_pkg::COUNT_W'($urandom_range(2, 15)));
            endcase
            // first set runs flat out on both sides
            tx_gap_max = (s == 0) ? 0 : GAP_MAX;
            rx_gap_max = (s == 0) ? 0 : GAP_MAX;
            for (k = 0; k < SET_ITEMS; k++)
                send_random_item();
        end
    endtask

    task automatic test_output_hold();
        int k;
        set_tone_count(5'd16);
        tx_gap_max = 0;
        rx_gap_max = 0;
        -> hold_start;
        for (k = 0; k < 25; k++)
            send_item(mtcg_pkg::OP_SAMPLE, '0, '0);
    endtask

    initial
    begin
        build_cos_quarter();
        for (int j = 0; j < NUM_TONES; j++)
        begin
            model_freq[j]  = '0;
            model_phase[j] = '0;
        end
        active_count = mtcg_pkg::COUNT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_random();
        test_output_hold();

        wait_idle();
        repeat (SETTLE_CYC) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            $error("sample: expected %0d more, actual none", expected_samples.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
